### sv/url_percent_escape_normalizer_defines.svh
// assertion helpers shared by the rtl files
`ifndef URL_PERCENT_ESCAPE_NORMALIZER_DEFINES_SVH
`define URL_PERCENT_ESCAPE_NORMALIZER_DEFINES_SVH

`ifndef SYNTHESIS

// property holds on every clock edge out of reset
`define UPEN_ASSERT(label, clk_sig, rstn_sig, prop) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (prop)) \
        else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define UPEN_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |=> (cons)) else $error("assertion failed");

`else

`define UPEN_ASSERT(label, clk_sig, rstn_sig, prop)
`define UPEN_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons)

`endif

`endif

### sv/upen_pkg.sv
package upen_pkg;

    localparam int QUEUE_DEPTH = 4;

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_CLASS_SELECT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_STRICT_MODE  = 1'b1;

    // safe class codes
    localparam logic [1:0] CLASS_PATH     = 2'd0;
    localparam logic [1:0] CLASS_QUERY    = 2'd1;
    localparam logic [1:0] CLASS_USERINFO = 2'd2;

    // lookahead fill codes
    localparam logic [1:0] HELD_NONE    = 2'd0;
    localparam logic [1:0] HELD_PCT     = 2'd1;
    localparam logic [1:0] HELD_PCT_HEX = 2'd2;

    localparam logic [7:0] CHAR_PCT = 8'h25;
    localparam logic [7:0] CHAR_TWO = 8'h32;
    localparam logic [7:0] CHAR_FIVE = 8'h35;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_end;
    } out_t;

    // how the main byte of a queue entry is written out
    typedef enum logic [1:0] {
        KIND_NONE = 2'b00,
        KIND_RAW  = 2'b01,
        KIND_ESC  = 2'b10,
        KIND_KEEP = 2'b11
    } kind_t;

    // back end segment of the current entry
    typedef enum logic [2:0] {
        SEG_P25  = 3'b001,
        SEG_H    = 3'b010,
        SEG_MAIN = 3'b100
    } seg_t;

    // one classified input item
    typedef struct packed {
        logic       pct25;
        logic       emit_h;
        logic [7:0] h_byte;
        kind_t      kind;
        logic [7:0] m_byte;
        logic       last;
    } entry_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        if (c inside {[8'h30:8'h39]})
            v = c - 8'h30;
        else if (c inside {[8'h41:8'h46]})
            v = c - 8'h37;
        else
            v = c - 8'h57;
        return v[3:0];
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + {4'd0, n};
        else
            return 8'h37 + {4'd0, n};
    endfunction

    function automatic logic [7:0] upper_hex(input logic [7:0] c);
        if (c inside {[8'h61:8'h66]})
            return c - 8'h20;
        else
            return c;
    endfunction

    function automatic logic is_sub_delim(input logic [7:0] c);
        return (c inside {8'h21, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B,
                          8'h2C, 8'h3B, 8'h3D});
    endfunction

    function automatic logic is_unreserved(input logic [7:0] c);
        return (c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39],
                          8'h2D, 8'h2E, 8'h5F, 8'h7E});
    endfunction

    function automatic logic is_reserved(input logic [7:0] c);
        return (c inside {8'h3A, 8'h2F, 8'h3F, 8'h23, 8'h5B, 8'h5D, 8'h40})
            || is_sub_delim(c);
    endfunction

    function automatic logic is_safe(input logic [7:0] c, input logic [1:0] cls);
        logic extra;
        case (cls)
            CLASS_QUERY:    extra = (c inside {8'h3A, 8'h40, 8'h2F, 8'h3F});
            CLASS_USERINFO: extra = (c == 8'h3A);
            default:        extra = (c inside {8'h3A, 8'h40, 8'h2F});
        endcase
        return is_unreserved(c) || is_sub_delim(c) || extra;
    endfunction

endpackage

### sv/upen_front.sv
module upen_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  upen_pkg::in_t     in_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        class_select,
    input  logic              strict_mode,
    input  logic              q_full,
    output logic              q_push,
    output upen_pkg::entry_t  q_entry
);

    logic [1:0] held_count_reg, held_count_next;
    logic [7:0] held_hex_reg, held_hex_next;
    logic       accept;
    logic       need_push;
    logic [7:0] b;
    logic       b_pct;
    logic       b_hex;
    logic       last;
    logic [7:0] dec;
    upen_pkg::kind_t b_kind;
    upen_pkg::kind_t dec_kind;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign q_push   = accept && need_push;

    assign b     = in_data.in_byte;
    assign last  = in_data.in_last;
    assign b_pct = (b == upen_pkg::CHAR_PCT);
    assign b_hex = upen_pkg::is_hex(b);
    assign dec   = {upen_pkg::hex_val(held_hex_reg), upen_pkg::hex_val(b)};

    assign b_kind = upen_pkg::is_safe(b, class_select) ? upen_pkg::KIND_RAW
                                                       : upen_pkg::KIND_ESC;

    always_comb
    begin
        if (strict_mode && !(upen_pkg::is_safe(dec, class_select) &&
                             !upen_pkg::is_reserved(dec)))
            dec_kind = upen_pkg::KIND_KEEP;
        else if (upen_pkg::is_safe(dec, class_select))
            dec_kind = upen_pkg::KIND_RAW;
        else
            dec_kind = upen_pkg::KIND_ESC;
    end

    always_comb
    begin
        need_push       = 1'b1;
        held_count_next = upen_pkg::HELD_NONE;
        held_hex_next   = held_hex_reg;
        q_entry.pct25   = 1'b0;
        q_entry.emit_h  = 1'b0;
        q_entry.h_byte  = held_hex_reg;
        q_entry.kind    = b_kind;
        q_entry.m_byte  = b;
        q_entry.last    = last;
        case (held_count_reg)
            upen_pkg::HELD_PCT:
            begin
                if (b_hex && !last)
                begin
                    // second byte of a possible triple
                    need_push       = 1'b0;
                    held_count_next = upen_pkg::HELD_PCT_HEX;
                    held_hex_next   = b;
                end
                else if (b_hex)
                begin
                    q_entry.pct25 = 1'b1;
                end
                else
                begin
                    q_entry.pct25 = 1'b1;
                    if (b_pct && !last)
                    begin
                        q_entry.kind    = upen_pkg::KIND_NONE;
                        held_count_next = upen_pkg::HELD_PCT;
                    end
                end
            end
            upen_pkg::HELD_PCT_HEX:
            begin
                if (b_hex)
                begin
                    // complete triple
                    q_entry.kind = dec_kind;
                    if (dec_kind != upen_pkg::KIND_KEEP)
                        q_entry.m_byte = dec;
                end
                else
                begin
                    q_entry.pct25  = 1'b1;
                    q_entry.emit_h = 1'b1;
                    if (b_pct && !last)
                    begin
                        q_entry.kind    = upen_pkg::KIND_NONE;
                        held_count_next = upen_pkg::HELD_PCT;
                    end
                end
            end
            default:
            begin
                // empty lookahead, also an inconsistent count
                if (b_pct && !last)
                begin
                    need_push       = 1'b0;
                    held_count_next = upen_pkg::HELD_PCT;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= upen_pkg::HELD_NONE;
            held_hex_reg   <= 8'h00;
        end
        else if (accept)
        begin
            held_count_reg <= held_count_next;
            held_hex_reg   <= held_hex_next;
        end
    end

endmodule

### sv/upen_queue.sv
`include "url_percent_escape_normalizer_defines.svh"

module upen_queue
#(
    parameter int DEPTH = upen_pkg::QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  upen_pkg::entry_t  push_data,
    output logic              full,
    input  logic              pop,
    output upen_pkg::entry_t  pop_data,
    output logic              empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    upen_pkg::entry_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    `UPEN_ASSERT(a_no_overflow, clk, rst_n, !(push && full))
    `UPEN_ASSERT(a_no_underflow, clk, rst_n, !(pop && empty))
    `UPEN_ASSERT_NEXT(a_count_tracks, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

### sv/upen_back.sv
`include "url_percent_escape_normalizer_defines.svh"

module upen_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  upen_pkg::entry_t  q_data,
    output logic              q_pop,
    output upen_pkg::out_t    out_data,
    output logic              out_valid,
    input  logic              out_stall
);

    upen_pkg::entry_t cur_reg, cur_next;
    logic             cur_valid_reg, cur_valid_next;
    upen_pkg::seg_t   seg_reg, seg_next;
    logic [1:0]       sub_reg, sub_next;
    upen_pkg::out_t   out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    logic       send;
    logic       final_now;
    logic       load;
    logic [7:0] byte_now;
    logic       main_none;
    upen_pkg::seg_t first_seg;

    assign main_none = (cur_reg.kind == upen_pkg::KIND_NONE);
    assign send      = cur_valid_reg && (!out_valid_reg || !out_stall);
    assign load      = (!cur_valid_reg || (send && final_now)) && !q_empty;
    assign q_pop     = load;

    assign out_data  = out_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        if (q_data.pct25)
            first_seg = upen_pkg::SEG_P25;
        else if (q_data.emit_h)
            first_seg = upen_pkg::SEG_H;
        else
            first_seg = upen_pkg::SEG_MAIN;
    end

    // byte at the current position and whether it closes the entry
    always_comb
    begin
        byte_now  = cur_reg.m_byte;
        final_now = 1'b0;
        case (seg_reg)
            upen_pkg::SEG_P25:
            begin
                case (sub_reg)
                    2'd0:    byte_now = upen_pkg::CHAR_PCT;
                    2'd1:    byte_now = upen_pkg::CHAR_TWO;
                    default: byte_now = upen_pkg::CHAR_FIVE;
                endcase
                final_now = (sub_reg == 2'd2) && !cur_reg.emit_h && main_none;
            end
            upen_pkg::SEG_H:
            begin
                byte_now  = cur_reg.h_byte;
                final_now = main_none;
            end
            upen_pkg::SEG_MAIN:
            begin
                case (cur_reg.kind)
                    upen_pkg::KIND_ESC:
                    begin
                        case (sub_reg)
                            2'd0:    byte_now = upen_pkg::CHAR_PCT;
                            2'd1:    byte_now = upen_pkg::hex_char(cur_reg.m_byte[7:4]);
                            default: byte_now = upen_pkg::hex_char(cur_reg.m_byte[3:0]);
                        endcase
                        final_now = (sub_reg == 2'd2);
                    end
                    upen_pkg::KIND_KEEP:
                    begin
                        case (sub_reg)
                            2'd0:    byte_now = upen_pkg::CHAR_PCT;
                            2'd1:    byte_now = upen_pkg::upper_hex(cur_reg.h_byte);
                            default: byte_now = upen_pkg::upper_hex(cur_reg.m_byte);
                        endcase
                        final_now = (sub_reg == 2'd2);
                    end
                    default:
                    begin
                        byte_now  = cur_reg.m_byte;
                        final_now = 1'b1;
                    end
                endcase
            end
            default:
            begin
                byte_now  = cur_reg.m_byte;
                final_now = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        seg_next       = seg_reg;
        sub_next       = sub_reg;
        if (load)
        begin
            cur_next       = q_data;
            cur_valid_next = 1'b1;
            seg_next       = first_seg;
            sub_next       = 2'd0;
        end
        else if (send && final_now)
        begin
            cur_valid_next = 1'b0;
        end
        else if (send)
        begin
            case (seg_reg)
                upen_pkg::SEG_P25:
                begin
                    if (sub_reg == 2'd2)
                    begin
                        seg_next = cur_reg.emit_h ? upen_pkg::SEG_H : upen_pkg::SEG_MAIN;
                        sub_next = 2'd0;
                    end
                    else
                    begin
                        sub_next = sub_reg + 2'd1;
                    end
                end
                upen_pkg::SEG_H:
                begin
                    seg_next = upen_pkg::SEG_MAIN;
                    sub_next = 2'd0;
                end
                default:
                begin
                    sub_next = sub_reg + 2'd1;
                end
            endcase
        end
    end

    always_comb
    begin
        out_next            = out_reg;
        out_valid_next      = out_valid_reg && out_stall;
        if (send)
        begin
            out_valid_next      = 1'b1;
            out_next.out_byte   = byte_now;
            out_next.run_last   = final_now;
            out_next.string_end = final_now && cur_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            seg_reg       <= upen_pkg::SEG_P25;
            sub_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            seg_reg       <= seg_next;
            sub_reg       <= sub_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    `UPEN_ASSERT(a_end_on_run_last, clk, rst_n, !(out_valid_reg && out_reg.string_end) || out_reg.run_last)
    `UPEN_ASSERT(a_h_single_beat, clk, rst_n, !(cur_valid_reg && seg_reg == upen_pkg::SEG_H) || sub_reg == 2'd0)
    `UPEN_ASSERT_NEXT(a_pop_loads, clk, rst_n, q_pop, cur_valid_reg)

endmodule

### sv/url_percent_escape_normalizer.sv
// channel   dir  handshake             beat payload
// in        in   in_valid / in_stall   in_data  : in_byte, in_last
// out       out  out_valid / out_stall out_data : out_byte, run_last, string_end
// cfg       in   cfg_we                cfg_index, cfg_data (no read-back)
//
// the front takes one input beat per cycle whenever the entry queue has room
// the back writes one output byte per cycle unless out_stall holds it: a lookahead-only item
// yields 0 bytes, a plain byte 1, an escape 3, a flushed broken triple with its next byte up to 7
// sustained rate is set by the back end byte sequencer and the output register
// reset clears the lookahead, the queue, the sequencer and both config registers
// out_stall holds the output register and the sequencer; input keeps flowing until the queue fills
module url_percent_escape_normalizer
#(
    parameter int QUEUE_DEPTH = upen_pkg::QUEUE_DEPTH
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  upen_pkg::in_t                   in_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    output upen_pkg::out_t                  out_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    input  logic                            cfg_we,
    input  logic [upen_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [upen_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // configuration registers; the user must write them only while the block is idle, the block does not enforce it
    logic [1:0] class_select_reg;
    logic       strict_mode_reg;

    // queue between classification and byte expansion
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    upen_pkg::entry_t q_in;
    upen_pkg::entry_t q_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_select_reg <= upen_pkg::CLASS_PATH;
            strict_mode_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                upen_pkg::REG_CLASS_SELECT: class_select_reg <= cfg_data[1:0];
                upen_pkg::REG_STRICT_MODE:  strict_mode_reg  <= cfg_data[0];
                default:                    strict_mode_reg  <= strict_mode_reg;
            endcase
        end
    end

    // front: lookahead on percent triples, at most one classified entry per input byte
    upen_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_data      (in_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .class_select (class_select_reg),
        .strict_mode  (strict_mode_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_entry      (q_in)
    );

    upen_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    // back: expands each entry into output beats, one byte per cycle unless out_stall holds it
    upen_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_out),
        .q_pop     (q_pop),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

endmodule
